// File: hdl/lsc_pkg.sv
`default_nettype none
package lsc_pkg;
   localparam int unsigned CHANNELS_DEF    = 8;
   localparam int unsigned SAMPLE_BITS_DEF = 12;
   localparam int unsigned NORM_TOP        = 1000;

   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [1:0] CSR_INVERT    = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_DETECT    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_SCALE,
      ST_DIVW,
      ST_ACCUM,
      ST_CDIV,
      ST_CWAIT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// File: hdl/line_sensor_centroid_core.sv
// channel | ports                         | handshake
// req     | req_action, req_raw_0..7      | req_valid / req_ready
// rsp     | rsp_position .. rsp_junction  | rsp_valid / rsp_ready
// csr     | csr_write, csr_index, csr_data| write enable, no wait
//
// A sample word runs, per channel, through a read, a scale step, a pass of the
// shared restoring divider and an accumulate step, then one more pass for the
// centroid; no new word is taken until its result has gone to the output register.
// Finish and unused commands leave the core idle; start first runs a clearing pass
// over all channels, and after reset a clearing pass runs before req_ready rises.
// The result sits in an output register; the next word is taken while it waits, and
// a following result waits in the core until that register is free.
`default_nettype none
module line_sensor_centroid_core #(
   parameter int unsigned SAMPLE_BITS = lsc_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_action,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_0,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_1,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_2,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_3,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_4,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_5,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_6,
   input  wire logic [SAMPLE_BITS-1:0] req_raw_7,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [10:0]          rsp_position,
   output logic [12:0]                 rsp_intensity_sum,
   output logic [3:0]                  rsp_active_count,
   output logic                        rsp_line_detected,
   output logic                        rsp_all_dark,
   output logic                        rsp_all_light,
   output logic                        rsp_junction,
   input  wire logic                   csr_write,
   input  wire logic [1:0]             csr_index,
   input  wire logic [12:0]            csr_data
);
   import lsc_pkg::*;

   localparam int unsigned CHANNELS = CHANNELS_DEF;
   localparam int unsigned SB   = SAMPLE_BITS;
   localparam int unsigned IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned SUMW = $clog2(CHANNELS * NORM_TOP + 1);
   localparam int unsigned ACW  = $clog2(CHANNELS + 1);
   localparam int unsigned DW   = SB + 10 > 32 ? (SB + 10) : 32;
   localparam int unsigned WSW  = SUMW + 12;
   localparam logic [SB-1:0] FULL = {SB{1'b1}};

   localparam logic [1:0] CL_LOW   = 2'd0;
   localparam logic [1:0] CL_HIGH  = 2'd1;
   localparam logic [1:0] CL_MID   = 2'd2;
   localparam logic [1:0] CL_EMPTY = 2'd3;

   logic signed [11:0] wtab [CHANNELS];

   for (genvar g = 0; g < CHANNELS; g++) begin : g_weight
      localparam int WV = ((2 * g - (int'(CHANNELS) - 1)) * 1000) / (int'(CHANNELS) - 1);
      assign wtab[g] = 12'(WV);
   end

   // memory of {min, max} per channel
   logic [2*SB-1:0] cal_mem [CHANNELS];
   logic [2*SB-1:0] rd_ff;
   logic            we;
   logic [IW-1:0]   wa;
   logic [2*SB-1:0] wd;

   state_type state_ff, state_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           cal_ff, cal_in;
   logic           inv_ff;
   logic [9:0]     thr_ff;
   logic [12:0]    dmin_ff;
   logic [SB-1:0]  raw_ff [CHANNELS];
   logic [SB-1:0]  lo_ff, lo_in, hi_ff, hi_in, rw;
   logic [1:0]     clamp_ff, clamp_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [ACW-1:0]  act_ff, act_in;
   logic signed [WSW-1:0] ws_ff, ws_in;
   logic [10:0]    v_ff, v_in, vq;
   logic signed [10:0] lastp_ff, lastp_in;
   logic           neg_ff, neg_in;
   logic [12:0] sum_o;
   logic [3:0]  act_o;
   logic        det_r;
   logic        div_start, div_busy;
   logic [DW-1:0] dvd, dvs, quo;
   logic [SB-1:0] raw_in [CHANNELS];
   logic [WSW-1:0] mag;

   assign raw_in[0] = req_raw_0;
   assign raw_in[1] = req_raw_1;
   assign raw_in[2] = req_raw_2;
   assign raw_in[3] = req_raw_3;
   assign raw_in[4] = req_raw_4;
   assign raw_in[5] = req_raw_5;
   assign raw_in[6] = req_raw_6;
   assign raw_in[7] = req_raw_7;

   logic take;
   assign take = req_valid && req_ready;
   assign rw   = raw_ff[idx_ff];
   assign mag  = ws_ff[WSW-1] ? WSW'(-ws_ff) : WSW'(ws_ff);

   always_ff @(posedge clock) begin
      if (we) cal_mem[wa] <= wd;
      rd_ff <= cal_mem[idx_in];
      if (take) for (int k = 0; k < CHANNELS; k++) raw_ff[k] <= raw_in[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 1'b0; thr_ff <= 10'd500; dmin_ff <= 13'd300;
      end else if (csr_write) begin
         case (csr_index)
            CSR_INVERT:    inv_ff  <= csr_data[0];
            CSR_THRESHOLD: thr_ff  <= csr_data[9:0];
            CSR_DETECT:    dmin_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (idx_ff == IW'(CHANNELS - 1)) state_in = ST_IDLE;
         ST_IDLE: if (take) begin
            if (req_action == ACT_START) state_in = ST_CLEAR;
            else if (req_action == ACT_SAMPLE) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIVW;
         ST_DIVW:  if (!div_busy) state_in = ST_ACCUM;
         ST_ACCUM: state_in = (idx_ff == IW'(CHANNELS - 1)) ? ST_CDIV : ST_READ;
         ST_CDIV:  state_in = ST_CWAIT;
         ST_CWAIT: if (!div_busy) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff; cal_in = cal_ff; we = 1'b0; wa = idx_ff; wd = {FULL, {SB{1'b0}}};
      lo_in = lo_ff; hi_in = hi_ff; clamp_in = clamp_ff; sum_in = sum_ff; act_in = act_ff;
      ws_in = ws_ff; v_in = v_ff; lastp_in = lastp_ff; neg_in = neg_ff;
      div_start = 1'b0; dvd = '0; dvs = '0;
      vq = 11'(quo);
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            wd = cal_ff ? {FULL, {SB{1'b0}}} : {{SB{1'b0}}, FULL};
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IW'(CHANNELS - 1)) idx_in = '0;
         end
         ST_IDLE: if (take) begin
            idx_in = '0; sum_in = '0; act_in = '0; ws_in = '0;
            if (req_action == ACT_START) cal_in = 1'b1;
            if (req_action == ACT_FINISH) cal_in = 1'b0;
         end
         ST_READ: begin
            lo_in = rd_ff[2*SB-1:SB]; hi_in = rd_ff[SB-1:0];
            if (cal_ff) begin
               if (rw < lo_in) lo_in = rw;
               if (rw > hi_in) hi_in = rw;
               we = 1'b1; wd = {lo_in, hi_in};
            end
         end
         ST_SCALE: begin
            clamp_in = (hi_ff <= lo_ff) ? CL_EMPTY : (rw <= lo_ff) ? CL_LOW :
                       (rw >= hi_ff) ? CL_HIGH : CL_MID;
            div_start = 1'b1;
            dvd = DW'(32'(rw - lo_ff) * 32'(NORM_TOP));
            dvs = DW'(hi_ff - lo_ff);
         end
         ST_DIVW: if (!div_busy) begin
            case (clamp_ff)
               CL_EMPTY: v_in = '0;
               CL_LOW:   v_in = inv_ff ? 11'd1000 : 11'd0;
               CL_HIGH:  v_in = inv_ff ? 11'd0 : 11'd1000;
               default:  v_in = inv_ff ? 11'(11'd1000 - vq) : vq;
            endcase
         end
         ST_ACCUM: begin
            sum_in = sum_ff + SUMW'(v_ff);
            if (v_ff >= {1'b0, thr_ff}) act_in = act_ff + 1'b1;
            ws_in = ws_ff + WSW'($signed({1'b0, v_ff})) * WSW'(wtab[idx_ff]);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IW'(CHANNELS - 1)) idx_in = '0;
         end
         ST_CDIV: begin
            div_start = 1'b1;
            dvd = DW'(mag); dvs = DW'(sum_ff);
            neg_in = ws_ff[WSW-1];
         end
         ST_CWAIT: if (!div_busy) begin
            if (det_r && sum_ff != '0)
               lastp_in = neg_ff ? -$signed(vq) : $signed(vq);
         end
         default: ;
      endcase
   end

   assign det_r = ({{(SUMW > 13 ? 0 : 13 - SUMW){1'b0}}, sum_ff} >= dmin_ff);

   lsc_divider #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(dvd), .divisor(dvs), .busy(div_busy), .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; idx_ff <= '0; cal_ff <= 1'b0; lastp_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; cal_ff <= cal_in; lastp_ff <= lastp_in;
         if (state_ff == ST_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; clamp_ff <= clamp_in; sum_ff <= sum_in;
      act_ff <= act_in; ws_ff <= ws_in; v_ff <= v_in; neg_ff <= neg_in;
      if (state_ff == ST_DONE && (!rsp_valid || rsp_ready)) begin
         rsp_position      <= lastp_ff;
         rsp_intensity_sum <= sum_o;
         rsp_active_count  <= act_o;
         rsp_line_detected <= det_r;
         rsp_all_dark      <= (act_ff == ACW'(CHANNELS));
         rsp_all_light     <= (act_ff == '0);
         rsp_junction      <= (act_ff >= ACW'(CHANNELS - 1));
      end
   end

   assign sum_o = (32'(sum_ff) > 32'h1FFF) ? 13'h1FFF : 13'(sum_ff);
   assign act_o = (32'(act_ff) > 32'd15) ? 4'hF : 4'(act_ff);
   assign req_ready = (state_ff == ST_IDLE);
endmodule
`default_nettype wire

// File: hdl/lsc_divider.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module lsc_divider #(
   parameter int unsigned W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic [W-1:0]      quotient
);
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    trial;

   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      trial  = {r_ff, q_ff[W-1]};
      if (start) begin
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = W'(trial - {1'b0, d_ff});
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = q_ff;
endmodule
`default_nettype wire

// File: hdl/lsc_checker.sv
`default_nettype none
module lsc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [12:0] rsp_intensity_sum,
   input wire logic [3:0]  rsp_active_count,
   input wire logic        rsp_all_dark,
   input wire logic        rsp_all_light
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_intensity_sum))
      else $error("rsp word changed while stalled");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_all_dark && rsp_all_light))
      else $error("dark and light together");
   a_light: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_light |-> rsp_active_count == 4'd0)
      else $error("light with active channels");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind line_sensor_centroid_core lsc_checker u_chk (.*);
`default_nettype wire
